// ----- hdl/srbf_pkg.sv -----
// srbf_pkg: types, constants and hash helper functions for the salted rotating
// Bloom filter. No dependencies; used by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none
package srbf_pkg;

    localparam int MAIN_FILTER_BITS   = 4096;
    localparam int MAIN_PROBES        = 4;
    localparam int IGNORE_FILTER_BITS = 1024;
    localparam int IGNORE_PROBES      = 3;
    localparam int PRINT_BITS         = 11;

    localparam int FP_W      = 11;
    localparam int FUNC_W    = 3;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SALT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SALT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SALT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SALT3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;
    localparam logic [TIME_W-1:0]    PERIOD_RESET = 32'd86400000;

    localparam logic [FP_W-1:0] PRINT_MASK = FP_W'((1 << PRINT_BITS) - 1);

    // filters are stored as 64-bit rows in one shared memory:
    // main bank 0, main bank 1, then the ignore filter
    localparam int ROW_W     = 64;
    localparam int COL_W     = 6;
    localparam int MAIN_BW   = $clog2(MAIN_FILTER_BITS);
    localparam int IGN_BW    = $clog2(IGNORE_FILTER_BITS);
    localparam int MAIN_ROWS = MAIN_FILTER_BITS / ROW_W;
    localparam int IGN_ROWS  = IGNORE_FILTER_BITS / ROW_W;
    localparam int IGN_BASE  = 2 * MAIN_ROWS;
    localparam int MEM_ROWS  = IGN_BASE + IGN_ROWS;
    localparam int MEM_AW    = $clog2(MEM_ROWS);
    localparam int MAIN_NP   = (MAIN_PROBES > 16) ? 16 : MAIN_PROBES;
    localparam int IGN_NP    = (IGNORE_PROBES > 16) ? 16 : IGNORE_PROBES;
    localparam int PI_W      = 4;

    localparam int MSG_LEN = 32 + 3;

    typedef logic [15:0][31:0] t_block;
    typedef logic [7:0][31:0]  t_digest;

    typedef enum logic [FUNC_W-1:0] {
        OP_NOTE    = 3'd0,
        OP_AQUERY  = 3'd1,
        OP_IADD    = 3'd2,
        OP_IQUERY  = 3'd3,
        OP_ICLEAR  = 3'd4,
        OP_TICK    = 3'd5,
        OP_ROTATE  = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_HASH,
        BS_RD,
        BS_CHK,
        BS_DONE
    } t_bstate;

    typedef struct packed {
        t_op               op;
        logic [FP_W-1:0]   fp;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic [3:0][63:0]  salt;
        logic [TIME_W-1:0] period;
    } t_cfg;

    typedef struct packed {
        logic hist;
        logic busy;
    } t_bstat;

    localparam logic [0:63][31:0] SHA_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_digest SHA_H0 = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // one padded block: salt, fingerprint low/high byte, zero, 0x80, length
    function automatic t_block make_block(input logic [255:0] salt,
                                          input logic [FP_W-1:0] fp);
        t_block      b;
        logic [15:0] fp16;
        logic [15:0] bits;
        fp16 = 16'(fp);
        bits = 16'(MSG_LEN * 8);
        b = '0;
        for (int j = 0; j < 8; j++) begin
            b[j] = {salt[32*j +: 8], salt[32*j+8 +: 8], salt[32*j+16 +: 8],
                    salt[32*j+24 +: 8]};
        end
        b[8]  = {fp16[7:0], fp16[15:8], 8'h00, 8'h80};
        b[15] = {16'h0000, bits};
        return b;
    endfunction

    // probe i: digest bytes 2i (low) and 2i+1 (high)
    function automatic logic [15:0] probe_slice(input t_digest dig,
                                                input logic [PI_W-1:0] i);
        logic [31:0] w;
        w = dig[i[PI_W-1:1]];
        return i[0] ? {w[7:0], w[15:8]} : {w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/salted_rotating_bloom_filter.sv -----
// salted_rotating_bloom_filter: top level; configuration registers, front
// queue and back end. Depends on srbf_pkg, srbf_front, srbf_back.
//
// Each transaction yields exactly one result. Note, ignore add and query
// transactions hash the salted fingerprint with one SHA-256 block (64 rounds,
// one per cycle, then the digest is finished and handed over) and then
// run a read state and a check state on the filter memory per probe, for
// 4 probes on the main filter and 3 on the ignore filter. Tick, rotate,
// ignore clear, code 7 and an ambient query before the first rotation skip
// the hash and go straight to the result state. A stalled result register
// holds the back end until the result is taken. The filters live in one
// memory of 64-bit rows with a valid bit per row, so rotation and ignore
// clear need no clearing pass over the memory, and none follows reset.
// A two-entry queue takes new transactions while one is executing.
`timescale 1ns / 1ps
`default_nettype none
module salted_rotating_bloom_filter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [srbf_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [srbf_pkg::FP_W-1:0]      i_fingerprint,
    input  wire logic [srbf_pkg::TIME_W-1:0]    i_now_time,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_match,
    output logic                               o_rotated,
    output logic                               o_history_valid,
    input  wire logic                          i_cfg_we,
    input  wire logic [srbf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [srbf_pkg::CFG_W-1:0]     i_cfg_data
);
    import srbf_pkg::*;

    t_cfg   r_cfg;
    t_item  w_item;
    logic   w_qvalid, w_pop;
    t_bstat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.salt   <= '0;
            r_cfg.period <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SALT0:  r_cfg.salt[0] <= i_cfg_data;
                CFG_SALT1:  r_cfg.salt[1] <= i_cfg_data;
                CFG_SALT2:  r_cfg.salt[2] <= i_cfg_data;
                CFG_SALT3:  r_cfg.salt[3] <= i_cfg_data;
                CFG_PERIOD: r_cfg.period <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    srbf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_fingerprint (i_fingerprint),
        .i_now_time    (i_now_time),
        .o_qvalid      (w_qvalid),
        .o_item        (w_item),
        .i_pop         (w_pop)
    );

    srbf_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_qvalid        (w_qvalid),
        .i_item          (w_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_match         (o_match),
        .o_rotated       (o_rotated),
        .o_history_valid (o_history_valid),
        .o_stat          (w_stat)
    );

`ifndef SYNTHESIS
    a_rot_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rotated) |-> o_history_valid)
        else $error("rotation reported without history valid");
    a_hist_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.hist |=> w_stat.hist)
        else $error("history valid dropped");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_qvalid && !w_stat.busy))
        else $error("queue popped while back end busy or queue empty");
`endif

endmodule
`default_nettype wire

// ----- hdl/srbf_front.sv -----
// srbf_front: input side; decodes each transaction and queues it in a
// two-entry FIFO for the back end. Depends on srbf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srbf_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [srbf_pkg::FUNC_W-1:0] i_func,
    input  wire logic [srbf_pkg::FP_W-1:0]   i_fingerprint,
    input  wire logic [srbf_pkg::TIME_W-1:0] i_now_time,
    output logic                            o_qvalid,
    output srbf_pkg::t_item                 o_item,
    input  wire logic                       i_pop
);
    import srbf_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_item      w_new;

    assign o_stall  = (r_cnt == 2'd2);
    assign o_qvalid = (r_cnt != 2'd0);
    assign o_item   = r_q[r_rp];
    assign push     = i_valid && !o_stall;

    always_comb begin
        w_new.op  = t_op'(i_func);
        w_new.fp  = i_fingerprint & PRINT_MASK;
        w_new.now = i_now_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            if (push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= w_new;
    end

endmodule
`default_nettype wire

// ----- hdl/srbf_sha.sv -----
// srbf_sha: single-block SHA-256, one round per cycle, digest registered.
// Depends on srbf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srbf_sha (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire srbf_pkg::t_block i_block,
    output logic                  o_done,
    output srbf_pkg::t_digest     o_digest
);
    import srbf_pkg::*;

    t_block      r_w;
    t_digest     r_s;
    t_digest     r_dig;
    logic [5:0]  r_cnt;
    logic        r_busy, r_fin, r_done;
    logic [31:0] t1, t2, w_next;

    assign o_done   = r_done;
    assign o_digest = r_dig;

    always_comb begin
        t1 = r_s[7] + big_s1(r_s[4]) + ((r_s[4] & r_s[5]) ^ (~r_s[4] & r_s[6]))
             + SHA_K[r_cnt] + r_w[0];
        t2 = big_s0(r_s[0]) + ((r_s[0] & r_s[1]) ^ (r_s[0] & r_s[2]) ^ (r_s[1] & r_s[2]));
        w_next = r_w[0] + small_s0(r_w[1]) + r_w[9] + small_s1(r_w[14]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w <= i_block;
            r_s <= SHA_H0;
        end else if (r_busy) begin
            for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
            r_w[15] <= w_next;
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= t1 + t2;
        end
        if (r_fin) begin
            for (int j = 0; j < 8; j++) r_dig[j] <= r_s[j] + SHA_H0[j];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/srbf_back.sv -----
// srbf_back: executes queued transactions: hashing, probe read-modify-write
// on the filter memory, rotation and the result register.
// Depends on srbf_pkg and srbf_sha.
`timescale 1ns / 1ps
`default_nettype none
module srbf_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire srbf_pkg::t_cfg  i_cfg,
    input  wire logic            i_qvalid,
    input  wire srbf_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_match,
    output logic                 o_rotated,
    output logic                 o_history_valid,
    output srbf_pkg::t_bstat     o_stat
);
    import srbf_pkg::*;

    t_bstate             r_state, n_state;
    t_item               r_item, n_item;
    logic [PI_W-1:0]     r_pi, n_pi;
    logic                r_match, n_match;
    logic                r_rot, n_rot;
    logic [MEM_AW-1:0]   r_addr, n_addr;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_tsel, n_tsel;
    logic                r_hist, n_hist;
    logic [TIME_W-1:0]   r_last, n_last;
    logic [MEM_ROWS-1:0] r_vld, n_vld;
    logic                r_ovalid, n_ovalid;
    logic                r_omatch, n_omatch, r_orot, n_orot, r_ohist, n_ohist;

    logic [ROW_W-1:0]    mem [MEM_ROWS];
    logic [ROW_W-1:0]    r_rdata;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_wd;
    logic [MEM_AW-1:0]   probe_addr;
    logic [COL_W-1:0]    probe_col;
    logic [ROW_W-1:0]    cur_row;
    logic [15:0]         p16;
    logic [TIME_W-1:0]   elapsed;
    logic                sha_start, sha_done, do_rot;
    logic                is_write, is_ign, is_query, last_probe, bank;
    t_digest             dig;

    srbf_sha u_sha (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sha_start),
        .i_block  (make_block(i_cfg.salt, i_item.fp)),
        .o_done   (sha_done),
        .o_digest (dig)
    );

    assign o_valid         = r_ovalid;
    assign o_match         = r_omatch;
    assign o_rotated       = r_orot;
    assign o_history_valid = r_ohist;
    assign o_stat.hist     = r_hist;
    assign o_stat.busy     = (r_state != BS_IDLE);

    always_comb begin
        is_write   = (r_item.op == OP_NOTE) || (r_item.op == OP_IADD);
        is_ign     = (r_item.op == OP_IADD) || (r_item.op == OP_IQUERY);
        is_query   = (r_item.op == OP_AQUERY) || (r_item.op == OP_IQUERY);
        bank       = (r_item.op == OP_NOTE) ? r_tsel : ~r_tsel;
        last_probe = is_ign ? (r_pi == PI_W'(IGN_NP - 1)) : (r_pi == PI_W'(MAIN_NP - 1));
        p16        = probe_slice(dig, r_pi);
        probe_col  = p16[COL_W-1:0];
        if (is_ign) begin
            probe_addr = MEM_AW'(IGN_BASE) + MEM_AW'(p16[IGN_BW-1:COL_W]);
        end else begin
            probe_addr = (bank ? MEM_AW'(MAIN_ROWS) : MEM_AW'(0))
                         + MEM_AW'(p16[MAIN_BW-1:COL_W]);
        end
        cur_row = r_vld[r_addr] ? r_rdata : '0;
        mem_wd  = cur_row | (ROW_W'(1) << r_col);
        elapsed = i_item.now - r_last;
    end

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_pi     = r_pi;
        n_match  = r_match;
        n_rot    = r_rot;
        n_addr   = r_addr;
        n_col    = r_col;
        n_tsel   = r_tsel;
        n_hist   = r_hist;
        n_last   = r_last;
        n_vld    = r_vld;
        n_ovalid = r_ovalid;
        n_omatch = r_omatch;
        n_orot   = r_orot;
        n_ohist  = r_ohist;
        o_pop     = 1'b0;
        sha_start = 1'b0;
        mem_we    = 1'b0;
        do_rot    = 1'b0;
        if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_qvalid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_pi    = '0;
                    n_match = 1'b1;
                    n_rot   = 1'b0;
                    n_state = BS_DONE;
                    case (i_item.op)
                        OP_NOTE, OP_IADD, OP_IQUERY: begin
                            sha_start = 1'b1;
                            n_state   = BS_HASH;
                        end
                        OP_AQUERY: begin
                            if (r_hist) begin
                                sha_start = 1'b1;
                                n_state   = BS_HASH;
                            end else begin
                                n_match = 1'b0;
                            end
                        end
                        OP_ICLEAR: begin
                            for (int k = 0; k < IGN_ROWS; k++) n_vld[IGN_BASE + k] = 1'b0;
                        end
                        OP_TICK: do_rot = (elapsed >= i_cfg.period);
                        OP_ROTATE: do_rot = 1'b1;
                        default: ;
                    endcase
                end
            end
            BS_HASH: begin
                if (sha_done) n_state = BS_RD;
            end
            BS_RD: begin
                n_addr  = probe_addr;
                n_col   = probe_col;
                n_state = BS_CHK;
            end
            BS_CHK: begin
                if (is_write) begin
                    mem_we        = 1'b1;
                    n_vld[r_addr] = 1'b1;
                end else if (!cur_row[r_col]) begin
                    n_match = 1'b0;
                end
                if (last_probe) begin
                    n_state = BS_DONE;
                end else begin
                    n_pi    = r_pi + PI_W'(1);
                    n_state = BS_RD;
                end
            end
            BS_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_omatch = r_match && is_query;
                    n_orot   = r_rot;
                    n_ohist  = r_hist;
                    n_state  = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
        // rotation: the old yesterday bank becomes today and is emptied
        if (do_rot) begin
            n_rot  = 1'b1;
            n_tsel = ~r_tsel;
            n_hist = 1'b1;
            n_last = i_item.now;
            for (int k = 0; k < MAIN_ROWS; k++) begin
                if (r_tsel) n_vld[k] = 1'b0;
                else n_vld[MAIN_ROWS + k] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_tsel   <= 1'b0;
            r_hist   <= 1'b0;
            r_last   <= '0;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tsel   <= n_tsel;
            r_hist   <= n_hist;
            r_last   <= n_last;
            r_vld    <= n_vld;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_pi     <= n_pi;
        r_match  <= n_match;
        r_rot    <= n_rot;
        r_addr   <= n_addr;
        r_col    <= n_col;
        r_omatch <= n_omatch;
        r_orot   <= n_orot;
        r_ohist  <= n_ohist;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_addr] <= mem_wd;
        r_rdata <= mem[probe_addr];
    end

endmodule
`default_nettype wire

// ----- tb/salted_rotating_bloom_filter_tb.sv -----
// salted_rotating_bloom_filter_tb: self-checking bench for the salted rotating Bloom filter.
// A queue-fed driver and a checking monitor compare every transaction against an in-bench
// SHA-256 based predictor. Depends on srbf_pkg and salted_rotating_bloom_filter.
`timescale 1ns / 1ps
module salted_rotating_bloom_filter_tb;
    import srbf_pkg::*;

    typedef struct {
        logic match;
        logic rotated;
        logic hist;
    } t_outcome;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [FP_W-1:0]      i_fingerprint = '0;
    logic [TIME_W-1:0]    i_now_time = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_match;
    logic                 o_rotated;
    logic                 o_history_valid;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    salted_rotating_bloom_filter DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [63:0]                   salt_m [4];
    logic [TIME_W-1:0]             period_m;
    logic [MAIN_FILTER_BITS-1:0]   today_m;
    logic [MAIN_FILTER_BITS-1:0]   yesterday_m;
    logic [IGNORE_FILTER_BITS-1:0] ignore_m;
    logic                          hist_m;
    logic [TIME_W-1:0]             last_rot_m;

    t_item    pending_items[$];
    t_outcome expected_outcomes[$];
    int       errors = 0;
    int       n_in = 0;
    int       n_out = 0;
    int       n_match = 0;
    int       n_rot = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // digest byte k sits in bits 8k+7..8k
    function automatic logic [255:0] salted_digest(input logic [FP_W-1:0] fp);
        logic [7:0]   msg [64];
        logic [31:0]  w [64];
        logic [31:0]  s [8];
        logic [31:0]  t1, t2, v, x, y;
        logic [255:0] dig;
        for (int i = 0; i < 64; i++) msg[i] = 8'h00;
        for (int i = 0; i < 32; i++) msg[i] = salt_m[i >> 3][8*(i & 7) +: 8];
        msg[32] = fp[7:0];
        msg[33] = 8'(fp >> 8);
        msg[35] = 8'h80;
        msg[62] = 8'h01;
        msg[63] = 8'h18;
        for (int i = 0; i < 16; i++)
            w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        end
        for (int i = 0; i < 8; i++) s[i] = SHA_H0[i];
        for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + SHA_K[i] + w[i];
            t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            v = s[i] + SHA_H0[i];
            dig[8*(4*i) +: 8]   = v[31:24];
            dig[8*(4*i+1) +: 8] = v[23:16];
            dig[8*(4*i+2) +: 8] = v[15:8];
            dig[8*(4*i+3) +: 8] = v[7:0];
        end
        return dig;
    endfunction

    function automatic logic [15:0] probe_pos(input logic [255:0] dig, input int p);
        return {dig[8*(2*p+1) +: 8], dig[8*(2*p) +: 8]};
    endfunction

    task automatic apply_filter_op(input t_op op, input logic [FP_W-1:0] fp_in,
                                   input logic [TIME_W-1:0] now);
        t_outcome     r;
        logic [255:0] dig;
        logic [FP_W-1:0] fp;
        fp = fp_in & PRINT_MASK;
        r = '{1'b0, 1'b0, 1'b0};
        dig = salted_digest(fp);
        case (op)
            OP_NOTE: begin
                for (int p = 0; p < MAIN_NP; p++)
                    today_m[probe_pos(dig, p) & (MAIN_FILTER_BITS - 1)] = 1'b1;
            end
            OP_AQUERY: begin
                if (hist_m) begin
                    r.match = 1'b1;
                    for (int p = 0; p < MAIN_NP; p++)
                        if (!yesterday_m[probe_pos(dig, p) & (MAIN_FILTER_BITS - 1)])
                            r.match = 1'b0;
                end
            end
            OP_IADD: begin
                for (int p = 0; p < IGN_NP; p++)
                    ignore_m[probe_pos(dig, p) & (IGNORE_FILTER_BITS - 1)] = 1'b1;
            end
            OP_IQUERY: begin
                r.match = 1'b1;
                for (int p = 0; p < IGN_NP; p++)
                    if (!ignore_m[probe_pos(dig, p) & (IGNORE_FILTER_BITS - 1)])
                        r.match = 1'b0;
            end
            OP_ICLEAR: ignore_m = '0;
            OP_TICK, OP_ROTATE: begin
                if (op == OP_ROTATE || (now - last_rot_m) >= period_m) begin
                    yesterday_m = today_m;
                    today_m = '0;
                    hist_m = 1'b1;
                    last_rot_m = now;
                    r.rotated = 1'b1;
                end
            end
            default: ;
        endcase
        r.hist = hist_m;
        expected_outcomes.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch at result %0d: %s got %0b expected %0b", n_out, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_item it;
        logic  busy;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            busy = i_valid && o_stall;
            if (i_valid && !o_stall) begin
                apply_filter_op(t_op'(i_func), i_fingerprint, i_now_time);
                n_in++;
            end
            if (!busy) begin
                if (pending_items.size() > 0 &&
                    ((n_in >= 120 && n_in < 300) || $urandom_range(99) >= 22)) begin
                    it = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_func <= it.op;
                    i_fingerprint <= it.fp;
                    i_now_time <= it.now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall, with one long hold-off
    int hold_cnt = 0;
    bit held = 1'b0;
    always @(posedge i_clk) begin
        t_outcome e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_outcomes.size() == 0) begin
                    report_mismatch("unexpected transaction", 1'b1, 1'b0);
                end else begin
                    e = expected_outcomes.pop_front();
                    if (o_match !== e.match) report_mismatch("match", o_match, e.match);
                    if (o_rotated !== e.rotated)
                        report_mismatch("rotated", o_rotated, e.rotated);
                    if (o_history_valid !== e.hist)
                        report_mismatch("history_valid", o_history_valid, e.hist);
                end
                n_match += o_match;
                n_rot += o_rotated;
                n_out++;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else if (!held && n_out >= 450) begin
                held = 1'b1;
                hold_cnt = 400;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !(n_out >= 120 && n_out < 300) && ($urandom_range(99) < 22);
            end
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    logic [TIME_W-1:0] clk_ms = '0;
    logic [FP_W-1:0]   fp_pool [8];

    function automatic t_item make_item(input t_op op, input logic [FP_W-1:0] fp,
                                        input logic [TIME_W-1:0] now);
        t_item it;
        it.op = op;
        it.fp = fp;
        it.now = now;
        return it;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_PERIOD) period_m = val[31:0];
        else salt_m[idx[1:0]] = val;
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || expected_outcomes.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [63:0] s0, input logic [63:0] s1,
                             input logic [63:0] s2, input logic [63:0] s3,
                             input logic [31:0] per, input int count);
        int   k;
        t_op  op;
        logic [FP_W-1:0] fp;
        drain();
        write_reg(CFG_SALT0, s0);
        write_reg(CFG_SALT1, s1);
        write_reg(CFG_SALT2, s2);
        write_reg(CFG_SALT3, s3);
        write_reg(CFG_PERIOD, {32'h0, per});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        for (int i = 0; i < 8; i++) fp_pool[i] = FP_W'($urandom);
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 25) op = OP_NOTE;
            else if (k < 45) op = OP_AQUERY;
            else if (k < 58) op = OP_IADD;
            else if (k < 78) op = OP_IQUERY;
            else if (k < 81) op = OP_ICLEAR;
            else if (k < 93) op = OP_TICK;
            else if (k < 98) op = OP_ROTATE;
            else op = OP_NONE;
            fp = ($urandom_range(99) < 60) ? fp_pool[$urandom_range(7)] : FP_W'($urandom);
            k = $urandom_range(99);
            if (k < 8) clk_ms = $urandom;
            else clk_ms = clk_ms + $urandom_range(0, (per > 2000) ? 2000 : per + per / 2);
            pending_items.push_back(make_item(op, fp, clk_ms));
        end
    endtask

    initial begin
        salt_m = '{default: 64'h0};
        period_m = PERIOD_RESET;
        today_m = '0;
        yesterday_m = '0;
        ignore_m = '0;
        hist_m = 1'b0;
        last_rot_m = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset config, history before and after rotation, time wrap
        pending_items.push_back(make_item(OP_AQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_NOTE, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_NOTE, 11'd2047, 32'd0));
        pending_items.push_back(make_item(OP_NOTE, 11'd1234, 32'd0));
        pending_items.push_back(make_item(OP_AQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_TICK, 11'd0, 32'd1000));
        pending_items.push_back(make_item(OP_TICK, 11'd0, 32'd86400000));
        pending_items.push_back(make_item(OP_AQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_AQUERY, 11'd2047, 32'd0));
        pending_items.push_back(make_item(OP_AQUERY, 11'd5, 32'd0));
        pending_items.push_back(make_item(OP_IADD, 11'd2047, 32'd0));
        pending_items.push_back(make_item(OP_IQUERY, 11'd2047, 32'd0));
        pending_items.push_back(make_item(OP_IQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_IADD, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_IQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_ICLEAR, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_IQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_NONE, 11'd2047, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(OP_ROTATE, 11'd0, 32'hFFFF_FFF0));
        pending_items.push_back(make_item(OP_TICK, 11'd0, 32'd5));
        pending_items.push_back(make_item(OP_AQUERY, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_NOTE, 11'd77, 32'd0));
        pending_items.push_back(make_item(OP_ROTATE, 11'd0, 32'd0));
        pending_items.push_back(make_item(OP_AQUERY, 11'd77, 32'd0));
        pending_items.push_back(make_item(OP_TICK, 11'd0, 32'hFFFF_FFFF));

        run_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 32'd1000, 140);
        run_phase('1, '1, '1, '1, 32'hFFFF_FFFF, 140);
        run_phase('0, '0, '0, '0, 32'd0, 140);
        run_phase({$urandom, $urandom}, '0, {$urandom, $urandom}, '1, 32'd1, 140);
        run_phase({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, 32'd300, 140);
        drain();

        $display("covered %0d transactions in, %0d results checked", n_in, n_out);
        $display("query hits %0d, rotations %0d, over six salt and period settings",
                 n_match, n_rot);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/srbf_pkg.sv
hdl/srbf_front.sv
hdl/srbf_sha.sv
hdl/srbf_back.sv
hdl/salted_rotating_bloom_filter.sv
tb/salted_rotating_bloom_filter_tb.sv
